>>> design/mtf_pkg.sv
// mtf_pkg: command, status and sequencer types for the min-tracking FIFO,
// plus default sizing constants.
// No dependencies.
package mtf_pkg;

  localparam int unsigned DEPTH_DEF      = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_FRONT   = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XFER_RD,
    S_XFER_WR,
    S_POP,
    S_DONE
  } state_t;

endpackage

>>> design/min_tracking_fifo.sv
// min_tracking_fifo: FIFO of signed words that reports its minimum, built
// from an input stack and an output stack held in two synchronous memories.
// Depends on mtf_pkg.
//
// Channel   Ports                                   Handshake
// -------   -------------------------------------   ------------------------------
// input     in_command, in_value                    taken when start && !busy
// result    out_status, out_data, out_count,        one cycle, marked by out_strobe
//           out_minimum, out_is_empty
//
// Sequence: enqueue, clear, front and a failing command go from acceptance
// through DONE to the result strobe. A dequeue that uncovers a new top of
// the output stack also passes through POP, since the next entry is read
// from the output-stack memory. A dequeue or front that finds the output
// stack empty first moves the input stack over, one in-stack read and one
// out-stack write per word, before DONE.
// Reset clears state, strobe and both stack sizes; the memories are not swept.
// The receiver cannot stall: each result is shown for exactly one cycle, and
// the next item may be taken in that same cycle.
module min_tracking_fifo
  import mtf_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW        = $clog2(DEPTH),
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_command,
  input  logic [DATA_WIDTH-1:0] in_value,
  output logic                  out_strobe,
  output logic [1:0]            out_status,
  output logic [DATA_WIDTH-1:0] out_data,
  output logic [CNT_W-1:0]      out_count,
  output logic [DATA_WIDTH-1:0] out_minimum,
  output logic                  out_is_empty
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  // Sequencer and stack bookkeeping
  state_t                  state_r, state_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  status_t                 status_r, status_nxt;
  logic [DATA_WIDTH-1:0]   data_r, data_nxt;
  logic [CNT_W-1:0]        in_size_r, in_size_nxt;
  logic [CNT_W-1:0]        out_size_r, out_size_nxt;

  // Cached tops: the in stack only ever needs its top running minimum, the
  // out stack its top word and top running minimum. Valid while size > 0.
  logic [DATA_WIDTH-1:0]   in_top_min_r, in_top_min_nxt;
  logic [DATA_WIDTH-1:0]   out_top_val_r, out_top_val_nxt;
  logic [DATA_WIDTH-1:0]   out_top_min_r, out_top_min_nxt;

  // Input-stack memory: words only
  logic [DATA_WIDTH-1:0]   in_mem [DEPTH];
  logic                    in_we;
  logic [AW-1:0]           in_wa;
  logic [AW-1:0]           in_ra;
  logic [DATA_WIDTH-1:0]   in_rd_q;

  // Output-stack memory: {word, running minimum}
  logic [2*DATA_WIDTH-1:0] out_mem [DEPTH];
  logic                    out_we;
  logic [AW-1:0]           out_wa;
  logic [2*DATA_WIDTH-1:0] out_wd;
  logic [AW-1:0]           out_ra;
  logic [2*DATA_WIDTH-1:0] out_rd_q;

  logic [CNT_W-1:0]        in_dec;
  logic [CNT_W-1:0]        out_dec2;
  logic [CNT_W-1:0]        total;
  logic [DATA_WIDTH-1:0]   enq_min;
  logic [DATA_WIDTH-1:0]   xfer_min;
  logic [DATA_WIDTH-1:0]   cur_min;

  // Result registers
  logic                    out_strobe_r;
  logic [1:0]              out_status_r;
  logic [DATA_WIDTH-1:0]   out_data_r;
  logic [CNT_W-1:0]        out_count_r;
  logic [DATA_WIDTH-1:0]   out_minimum_r;
  logic                    out_is_empty_r;

  assign in_dec   = in_size_r - CNT_W'(1);
  assign out_dec2 = out_size_r - CNT_W'(2);
  assign total    = in_size_r + out_size_r;

  // Running minimum for a new in-stack top
  assign enq_min = (in_size_r == '0 || $signed(in_value) <= $signed(in_top_min_r))
                   ? in_value : in_top_min_r;
  // Running minimum for a word moved onto the out stack
  assign xfer_min = (out_size_r == '0 || $signed(in_rd_q) <= $signed(out_top_min_r))
                    ? in_rd_q : out_top_min_r;

  // Queue minimum is the lesser of the two top minima
  always_comb begin
    if (in_size_r != '0 && out_size_r != '0) begin
      cur_min = ($signed(in_top_min_r) <= $signed(out_top_min_r))
                ? in_top_min_r : out_top_min_r;
    end else if (in_size_r != '0) begin
      cur_min = in_top_min_r;
    end else if (out_size_r != '0) begin
      cur_min = out_top_min_r;
    end else begin
      cur_min = '0;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Memory address defaults: the in stack is always read at its top, the out
  // stack at the entry just below its top.
  assign in_wa  = in_size_r[AW-1:0];
  assign in_ra  = in_dec[AW-1:0];
  assign out_wa = out_size_r[AW-1:0];
  assign out_ra = out_dec2[AW-1:0];
  assign out_wd = {in_rd_q, xfer_min};

  always_ff @(posedge clk) begin
    if (in_we) begin
      in_mem[in_wa] <= in_value;
    end
    in_rd_q <= in_mem[in_ra];
  end

  always_ff @(posedge clk) begin
    if (out_we) begin
      out_mem[out_wa] <= out_wd;
    end
    out_rd_q <= out_mem[out_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_size_r  <= '0;
      out_size_r <= '0;
    end else begin
      state_r    <= state_nxt;
      in_size_r  <= in_size_nxt;
      out_size_r <= out_size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r         <= cmd_nxt;
    status_r      <= status_nxt;
    data_r        <= data_nxt;
    in_top_min_r  <= in_top_min_nxt;
    out_top_val_r <= out_top_val_nxt;
    out_top_min_r <= out_top_min_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    status_nxt      = status_r;
    data_nxt        = data_r;
    in_size_nxt     = in_size_r;
    out_size_nxt    = out_size_r;
    in_top_min_nxt  = in_top_min_r;
    out_top_val_nxt = out_top_val_r;
    out_top_min_nxt = out_top_min_r;
    in_we           = 1'b0;
    out_we          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt    = cmd_t'(in_command);
          status_nxt = ST_OK;
          data_nxt   = '0;
          state_nxt  = S_DONE;
          unique case (cmd_t'(in_command))
            CMD_ENQUEUE: begin
              if (total == DEPTH_C) begin
                status_nxt = ST_FULL;
              end else begin
                in_we          = 1'b1;
                in_top_min_nxt = enq_min;
                in_size_nxt    = in_size_r + CNT_W'(1);
              end
            end
            CMD_DEQUEUE, CMD_FRONT: begin
              if (out_size_r != '0) begin
                data_nxt = out_top_val_r;
                if (cmd_t'(in_command) == CMD_DEQUEUE) begin
                  out_size_nxt = out_size_r - CNT_W'(1);
                  // new top must come back from memory
                  if (out_size_r > CNT_W'(1)) begin
                    state_nxt = S_POP;
                  end
                end
              end else if (in_size_r != '0) begin
                state_nxt = S_XFER_RD;
              end else begin
                status_nxt = ST_EMPTY;
              end
            end
            CMD_CLEAR: begin
              in_size_nxt  = '0;
              out_size_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      // in-stack top is being read
      S_XFER_RD: begin
        state_nxt = S_XFER_WR;
      end

      S_XFER_WR: begin
        in_size_nxt = in_dec;
        if (in_size_r == CNT_W'(1)) begin
          // last word moved is the new front
          data_nxt  = in_rd_q;
          state_nxt = S_DONE;
          // a dequeue takes it straight away; the cached tops stay as they are
          if (cmd_r != CMD_DEQUEUE) begin
            out_we          = 1'b1;
            out_size_nxt    = out_size_r + CNT_W'(1);
            out_top_val_nxt = in_rd_q;
            out_top_min_nxt = xfer_min;
          end
        end else begin
          out_we          = 1'b1;
          out_size_nxt    = out_size_r + CNT_W'(1);
          out_top_val_nxt = in_rd_q;
          out_top_min_nxt = xfer_min;
          state_nxt       = S_XFER_RD;
        end
      end

      S_POP: begin
        out_top_val_nxt = out_rd_q[2*DATA_WIDTH-1:DATA_WIDTH];
        out_top_min_nxt = out_rd_q[DATA_WIDTH-1:0];
        state_nxt       = S_DONE;
      end

      S_DONE: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result is formed from the settled state in DONE, registered and shown in the following cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_status_r   <= status_r;
      out_data_r     <= data_r;
      out_count_r    <= total;
      out_minimum_r  <= cur_min;
      out_is_empty_r <= (total == '0);
    end
  end

  assign out_strobe   = out_strobe_r;
  assign out_status   = out_status_r;
  assign out_data     = out_data_r;
  assign out_count    = out_count_r;
  assign out_minimum  = out_minimum_r;
  assign out_is_empty = out_is_empty_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, in_size_r} + {1'b0, out_size_r}) <= {1'b0, DEPTH_C})
    else $error("stack sizes exceed depth");

  a_xfer_source: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_XFER_RD || state_r == S_XFER_WR) |-> (in_size_r != '0 && out_size_r != DEPTH_C))
    else $error("transfer with empty in stack or full out stack");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == S_DONE))
    else $error("result strobe without completed command");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == ST_FULL) |-> (out_count == DEPTH_C))
    else $error("full status with room left");

endmodule

>>> tb/min_tracking_fifo_checker.sv
// min_tracking_fifo_checker: watches the command and result channels of the
// min-tracking FIFO, predicts each result and compares it field by field.
// Depends on mtf_pkg.
module min_tracking_fifo_checker
  import mtf_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF,
  parameter int unsigned W     = DATA_WIDTH_DEF,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       in_command,
  input  logic [W-1:0]     in_value,
  input  logic             out_strobe,
  input  logic [1:0]       out_status,
  input  logic [W-1:0]     out_data,
  input  logic [CNT_W-1:0] out_count,
  input  logic [W-1:0]     out_minimum,
  input  logic             out_is_empty,
  output int               mismatches,
  output int               outstanding,
  output int               replies_checked,
  output int               full_rejects,
  output int               empty_reads
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [W-1:0] word_t;

  typedef struct {
    status_t          status;
    word_t            data;
    logic [CNT_W-1:0] count;
    word_t            minimum;
    logic             is_empty;
  } reply_t;

  // Two stacks, each entry with its running minimum from the bottom up.
  word_t       in_words  [DEPTH];
  word_t       in_mins   [DEPTH];
  word_t       out_words [DEPTH];
  word_t       out_mins  [DEPTH];
  int unsigned in_depth;
  int unsigned out_depth;

  reply_t replies_due[$];
  reply_t head;
  reply_t fresh;

  function automatic word_t lesser(word_t a, word_t b);
    return (a <= b) ? a : b;
  endfunction

  function automatic reply_t predict_reply(cmd_t cmd, word_t value);
    reply_t r;
    word_t  w;
    r.status  = ST_OK;
    r.data    = '0;
    r.minimum = '0;
    case (cmd)
      CMD_ENQUEUE: begin
        if (in_depth + out_depth >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          in_mins[in_depth]  = (in_depth == 0) ? value : lesser(value, in_mins[in_depth-1]);
          in_words[in_depth] = value;
          in_depth++;
        end
      end
      CMD_DEQUEUE, CMD_FRONT: begin
        // empty output stack: pour the input stack over, reversing it
        if (out_depth == 0) begin
          while (in_depth > 0 && out_depth < DEPTH) begin
            in_depth--;
            w = in_words[in_depth];
            out_mins[out_depth]  = (out_depth == 0) ? w : lesser(w, out_mins[out_depth-1]);
            out_words[out_depth] = w;
            out_depth++;
          end
        end
        if (out_depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = out_words[out_depth-1];
          if (cmd == CMD_DEQUEUE) out_depth--;
        end
      end
      default: begin
        in_depth  = 0;
        out_depth = 0;
      end
    endcase
    r.count = CNT_W'(in_depth + out_depth);
    if (in_depth > 0 && out_depth > 0) begin
      r.minimum = lesser(in_mins[in_depth-1], out_mins[out_depth-1]);
    end else if (in_depth > 0) begin
      r.minimum = in_mins[in_depth-1];
    end else if (out_depth > 0) begin
      r.minimum = out_mins[out_depth-1];
    end
    r.is_empty = (in_depth + out_depth == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic [W-1:0] want, logic [W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%h, actual 0x%h", name, want, got);
      mismatches++;
    end
  endtask

  // Results are compared before the new item is predicted: a strobe at the
  // same edge always belongs to an earlier item.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_depth  = 0;
      out_depth = 0;
      replies_due.delete();
    end else begin
      if (out_strobe) begin
        if (replies_due.size() == 0) begin
          $error("result with nothing pending: status %0d, data 0x%h", out_status, out_data);
          mismatches++;
        end else begin
          head = replies_due.pop_front();
          check_field("status", W'(head.status), W'(out_status));
          check_field("data", head.data, out_data);
          check_field("count", W'(head.count), W'(out_count));
          check_field("minimum", head.minimum, out_minimum);
          check_field("is_empty", W'(head.is_empty), W'(out_is_empty));
          replies_checked++;
        end
      end
      if (start && !busy) begin
        fresh = predict_reply(cmd_t'(in_command), in_value);
        if (fresh.status == ST_FULL) full_rejects++;
        if (fresh.status == ST_EMPTY) empty_reads++;
        replies_due.push_back(fresh);
      end
    end
    outstanding = replies_due.size();
  end

endmodule

>>> tb/tb_min_tracking_fifo.sv
// tb_min_tracking_fifo: drives command items into the min-tracking FIFO and
// gives the verdict; checking is done by min_tracking_fifo_checker.
// Depends on mtf_pkg, min_tracking_fifo and min_tracking_fifo_checker.
module tb_min_tracking_fifo;
  timeunit 1ns;
  timeprecision 1ps;
  import mtf_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned W     = DATA_WIDTH_DEF;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [W-1:0] MAX_WORD = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MIN_WORD = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ALT_0101 = {(W/2){2'b01}};
  localparam logic [W-1:0] ALT_1010 = {(W/2){2'b10}};

  // Slowest gap between handshakes is a full stack transfer, one in-stack read
  // and one out-stack write per word; give it plenty of room.
  localparam int STALL_LIMIT = 8 * DEPTH + 200;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_command;
  logic [W-1:0]     in_value;
  logic             out_strobe;
  logic [1:0]       out_status;
  logic [W-1:0]     out_data;
  logic [CNT_W-1:0] out_count;
  logic [W-1:0]     out_minimum;
  logic             out_is_empty;

  int mismatches;
  int outstanding;
  int replies_checked;
  int full_rejects;
  int empty_reads;

  int items_sent;
  int cmd_hits[4];
  int stall_cycles;
  bit idle_on;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  min_tracking_fifo dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_status   (out_status),
    .out_data     (out_data),
    .out_count    (out_count),
    .out_minimum  (out_minimum),
    .out_is_empty (out_is_empty)
  );

  min_tracking_fifo_checker #(.DEPTH(DEPTH), .W(W), .CNT_W(CNT_W)) reply_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_data        (out_data),
    .out_count       (out_count),
    .out_minimum     (out_minimum),
    .out_is_empty    (out_is_empty),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .replies_checked (replies_checked),
    .full_rejects    (full_rejects),
    .empty_reads     (empty_reads)
  );

  // Watchdog: any accepted item or result restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one item and hold it until the edge that takes it. Called right
  // after a rising edge; start stays high if the next item follows at once.
  task automatic issue(input cmd_t cmd, input logic [W-1:0] value);
    start      <= 1'b1;
    in_command <= cmd;
    in_value   <= value;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    cmd_hits[cmd]++;
  endtask

  // Random sender gap before roughly one item in six, while gaps are enabled.
  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Hold off until every predicted result has come back. Sampled on the
  // falling edge so the checker's count is settled.
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Mix of full-range words, extremes and a narrow band that forces ties.
  function automatic logic [W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return MIN_WORD;
          1:       return MAX_WORD;
          2:       return '0;
          3:       return '1;
          default: return W'(1);
        endcase
      end
      1, 2, 3: return W'($urandom_range(0, 8)) - W'(4);
      default: return W'($urandom);
    endcase
  endfunction

  // Weighted command pick in percent; whatever is left over is clear.
  function automatic cmd_t pick_cmd(int enq_pct, int deq_pct, int front_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) return CMD_ENQUEUE;
    if (roll < enq_pct + deq_pct) return CMD_DEQUEUE;
    if (roll < enq_pct + deq_pct + front_pct) return CMD_FRONT;
    return CMD_CLEAR;
  endfunction

  initial begin
    int run;
    int enq_issued;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_command = CMD_ENQUEUE;
    in_value   = '0;
    idle_on    = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    // reads and clear on a freshly reset queue
    issue(CMD_DEQUEUE, pick_word());
    issue(CMD_FRONT, pick_word());
    issue(CMD_CLEAR, pick_word());
    // extremes, zero, minus one and repeated words for tied minima
    issue(CMD_ENQUEUE, MAX_WORD);
    issue(CMD_ENQUEUE, MIN_WORD);
    issue(CMD_ENQUEUE, '0);
    issue(CMD_ENQUEUE, '1);
    issue(CMD_ENQUEUE, MAX_WORD);
    issue(CMD_ENQUEUE, W'(5));
    issue(CMD_ENQUEUE, W'(5));
    // front finds the output stack empty and pulls all seven words over
    issue(CMD_FRONT, pick_word());
    // both stacks now hold words; minimum comes from their two tops
    issue(CMD_ENQUEUE, -W'(7));
    issue(CMD_ENQUEUE, MIN_WORD);
    issue(CMD_DEQUEUE, pick_word());
    issue(CMD_DEQUEUE, pick_word());
    issue(CMD_DEQUEUE, pick_word());
    issue(CMD_FRONT, pick_word());
    // clear leaves stale words behind; they must not show
    issue(CMD_CLEAR, pick_word());
    issue(CMD_FRONT, pick_word());
    issue(CMD_DEQUEUE, pick_word());
    issue(CMD_ENQUEUE, ALT_0101);
    issue(CMD_ENQUEUE, ALT_1010);
    issue(CMD_DEQUEUE, pick_word());
    issue(CMD_DEQUEUE, pick_word());
    issue(CMD_DEQUEUE, pick_word());

    // let the block run dry once before the random part
    wait_drained();

    // ---- random push/pop runs ----
    // a burst of pushes, then a burst of pops; pops past empty are the noise
    while (items_sent < 60) begin
      run = $urandom_range(1, 40);
      repeat (run) begin
        maybe_idle();
        issue(($urandom_range(0, 9) == 0) ? CMD_FRONT : CMD_ENQUEUE, pick_word());
      end
      run = $urandom_range(1, 40);
      repeat (run) begin
        maybe_idle();
        issue(pick_cmd(5, 60, 30), pick_word());
      end
    end

    // ---- fill to capacity ----
    // interleaved fronts split the words across both stacks along the way
    issue(CMD_CLEAR, pick_word());
    enq_issued = 0;
    while (enq_issued < DEPTH) begin
      maybe_idle();
      if ($urandom_range(0, 39) == 0) begin
        issue(CMD_FRONT, pick_word());
      end else begin
        issue(CMD_ENQUEUE, pick_word());
        enq_issued++;
      end
    end
    // full: pushes refused, then one slot freed and taken again
    repeat (3) issue(CMD_ENQUEUE, pick_word());
    issue(CMD_FRONT, pick_word());
    issue(CMD_DEQUEUE, pick_word());
    issue(CMD_ENQUEUE, MIN_WORD);
    issue(CMD_ENQUEUE, MAX_WORD);

    // ---- back-to-back tail, no gaps ----
    idle_on = 1'b0;
    repeat (30) issue(pick_cmd(25, 50, 20), pick_word());

    wait_drained();
    repeat (8) @(posedge clk);
    @(negedge clk);

    $display("Covered %0d items: %0d enqueue, %0d dequeue, %0d front, %0d clear",
             items_sent, cmd_hits[CMD_ENQUEUE], cmd_hits[CMD_DEQUEUE],
             cmd_hits[CMD_FRONT], cmd_hits[CMD_CLEAR]);
    $display("%0d results compared, %0d pushes refused at capacity, %0d reads of an empty queue",
             replies_checked, full_rejects, empty_reads);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
